[hdl/moisture_piecewise_interpolator_macros.svh]
// Assertion macros used by the checker file.
`ifndef MOISTURE_PIECEWISE_INTERPOLATOR_MACROS_SVH
`define MOISTURE_PIECEWISE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define MPI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define MPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Implication that is also checked on the edge that leaves reset.
`define MPI_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/mpi_pkg.sv]
`timescale 1ns / 1ps

package mpi_pkg;

  // Default number of calibration points
  localparam int unsigned MPI_POINT_COUNT = 11;

  // Field and datapath widths
  localparam int unsigned RAW_W    = 14;
  localparam int unsigned PT_W     = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned SEG_W    = 4;
  localparam int unsigned QUO_W    = 4;
  localparam int unsigned REM_W    = 18;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned HIGH_W   = 48;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned GROUP_PT = 4;
  localparam int unsigned GROUP_N  = 3;

  // Register reset values (points 1700 + k*118, last point 3000)
  localparam logic [CFG_W-1:0]  RST_LOW  = 64'd578157917339518628;
  localparam logic [CFG_W-1:0]  RST_MID  = 64'd711016133602445436;
  localparam logic [HIGH_W-1:0] RST_HIGH = 48'd12885082901076;

  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] ZERO_PCT   = 7'd0;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_LOW  = 2'd0,
    CFG_MID  = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_idx_e;

  // Data handed along the scan cells
  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             rd_valid;
    logic             found;
    logic [SEG_W-1:0] seg;
    logic [RAW_W-1:0] diff;
    logic [PT_W-1:0]  span;
  } scan_t;

  // Data handed along the divider cells
  typedef struct packed {
    logic             rd_valid;
    logic             found;
    logic [SEG_W-1:0] seg;
    logic [REM_W-1:0] rem;
    logic [PT_W-1:0]  span;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

[hdl/mpi_scan_cell.sv]
`timescale 1ns / 1ps

module mpi_scan_cell
  import mpi_pkg::*;
#(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  scan_t           data_i,
  input  logic [PT_W-1:0] hi_i,
  input  logic [PT_W-1:0] lo_i,
  output logic            valid_o,
  input  logic            ready_i,
  output scan_t           data_o
);

  logic             valid_q;
  scan_t            data_q, data_d;
  logic             hit;
  logic [PT_W-1:0]  sub;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Compare against this cell's point; the earlier points are all at or below raw
  assign hit = data_i.rd_valid && !data_i.found && ({2'b00, data_i.raw} < hi_i);
  assign sub = {2'b00, data_i.raw} - lo_i;

  always_comb begin
    data_d = data_i;
    if (hit) begin
      data_d.found = 1'b1;
      if (K == 0) begin
        // below the first point: zero quotient and zero base
        data_d.seg  = '0;
        data_d.diff = '0;
        data_d.span = PT_W'(1);
      end else begin
        data_d.seg  = SEG_W'(K - 1);
        data_d.diff = sub[RAW_W-1:0];
        data_d.span = hi_i - lo_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[hdl/mpi_div_cell.sv]
`timescale 1ns / 1ps

module mpi_div_cell
  import mpi_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  localparam int unsigned EXT_W = PT_W + QUO_W - 1;

  logic             valid_q;
  div_t             data_q, data_d;
  logic [EXT_W-1:0] shifted;
  logic [EXT_W-1:0] rem_ext;
  logic [EXT_W-1:0] rem_sub;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // One restoring step: quotient bit BIT
  assign shifted = EXT_W'(data_i.span) << BIT;
  assign rem_ext = EXT_W'(data_i.rem);
  assign rem_sub = rem_ext - shifted;

  always_comb begin
    data_d = data_i;
    if (rem_ext >= shifted) begin
      data_d.rem      = rem_sub[REM_W-1:0];
      data_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[hdl/moisture_piecewise_interpolator.sv]
// Pipeline: one scan cell per point, four divider cells, one output register.
// Throughput: one reading per cycle unless out_ready_i stalls the output;
// every cell is a pipeline stage with its own valid.
// Reset: asynchronous, active low; clears all stage valids and loads the default
// calibration points (1700 + k*118, last point 3000).
`timescale 1ns / 1ps

module moisture_piecewise_interpolator
  import mpi_pkg::*;
#(
  parameter int unsigned POINT_COUNT = MPI_POINT_COUNT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RAW_W-1:0] raw_capacitance_i,
  input  logic             reading_valid_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PCT_W-1:0] moisture_percent_o,
  output logic             result_valid_o
);

  localparam int unsigned PTS_W = GROUP_N * GROUP_PT * PT_W;

  // Configuration registers
  logic [CFG_W-1:0]  grp_low_q, grp_mid_q;
  logic [HIGH_W-1:0] grp_high_q;
  logic [PTS_W-1:0]  pts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_low_q  <= RST_LOW;
      grp_mid_q  <= RST_MID;
      grp_high_q <= RST_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOW:  grp_low_q  <= cfg_wdata_i;
        CFG_MID:  grp_mid_q  <= cfg_wdata_i;
        CFG_HIGH: grp_high_q <= cfg_wdata_i[HIGH_W-1:0];
        default:  ;
      endcase
    end
  end

  // Missing top point reads as zero and never hits
  assign pts = {{(CFG_W - HIGH_W){1'b0}}, grp_high_q, grp_mid_q, grp_low_q};

  // Scan chain
  scan_t scan_s [POINT_COUNT+1];
  logic  scan_v [POINT_COUNT+1];
  logic  scan_r [POINT_COUNT+1];

  always_comb begin
    scan_s[0]          = '0;
    scan_s[0].raw      = raw_capacitance_i;
    scan_s[0].rd_valid = reading_valid_i;
  end
  assign scan_v[0]  = in_valid_i;
  assign in_ready_o = scan_r[0];

  for (genvar k = 0; k < POINT_COUNT; k++) begin : g_scan
    logic [PT_W-1:0] lo;
    if (k == 0) begin : g_first
      assign lo = '0;
    end else begin : g_rest
      assign lo = pts[(k-1)*PT_W +: PT_W];
    end
    mpi_scan_cell #(.K(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (scan_v[k]),
      .ready_o (scan_r[k]),
      .data_i  (scan_s[k]),
      .hi_i    (pts[k*PT_W +: PT_W]),
      .lo_i    (lo),
      .valid_o (scan_v[k+1]),
      .ready_i (scan_r[k+1]),
      .data_o  (scan_s[k+1])
    );
  end

  // Divider chain; dividend is 10 * (raw - lo)
  div_t div_s [QUO_W+1];
  logic div_v [QUO_W+1];
  logic div_r [QUO_W+1];

  always_comb begin
    div_s[0].rd_valid = scan_s[POINT_COUNT].rd_valid;
    div_s[0].found    = scan_s[POINT_COUNT].found;
    div_s[0].seg      = scan_s[POINT_COUNT].seg;
    div_s[0].span     = scan_s[POINT_COUNT].span;
    div_s[0].rem      = {1'b0, scan_s[POINT_COUNT].diff, 3'b000}
                      + {3'b000, scan_s[POINT_COUNT].diff, 1'b0};
    div_s[0].quo      = '0;
  end
  assign div_v[0]           = scan_v[POINT_COUNT];
  assign scan_r[POINT_COUNT] = div_r[0];

  for (genvar b = 0; b < QUO_W; b++) begin : g_div
    mpi_div_cell #(.BIT(QUO_W - 1 - b)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[b]),
      .ready_o (div_r[b]),
      .data_i  (div_s[b]),
      .valid_o (div_v[b+1]),
      .ready_i (div_r[b+1]),
      .data_o  (div_s[b+1])
    );
  end

  // Result assembly: base 10*seg plus quotient, saturated; an invalid reading gives zero
  logic             out_valid_q;
  logic [PCT_W-1:0] pct_q, pct_d;
  logic             rv_q;
  logic             out_rdy;
  logic [PCT_W-1:0] seg_sum;
  div_t             fin;

  assign fin     = div_s[QUO_W];
  assign seg_sum = PCT_W'({fin.seg, 3'b000}) + PCT_W'({fin.seg, 1'b0}) + PCT_W'(fin.quo);

  always_comb begin
    if (!fin.rd_valid) begin
      pct_d = ZERO_PCT;
    end else if (!fin.found || (seg_sum > FULL_SCALE)) begin
      pct_d = FULL_SCALE;
    end else begin
      pct_d = seg_sum;
    end
  end

  assign out_rdy      = !out_valid_q || out_ready_i;
  assign div_r[QUO_W] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= div_v[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_v[QUO_W]) begin
      pct_q <= pct_d;
      rv_q  <= fin.rd_valid;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign moisture_percent_o = pct_q;
  assign result_valid_o     = rv_q;

endmodule

[hdl/mpi_checker.sv]
`timescale 1ns / 1ps
`include "moisture_piecewise_interpolator_macros.svh"

module mpi_checker
  import mpi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PCT_W-1:0] moisture_percent_o,
  input logic             result_valid_o
);

  // An invalid reading reports zero percent
  `MPI_ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni, out_valid_o && !result_valid_o, moisture_percent_o == ZERO_PCT, "invalid reading with nonzero percent")

  // Percent never exceeds full scale
  `MPI_ASSERT_IMPL(a_pct_range, clk_i, rst_ni, out_valid_o, moisture_percent_o <= FULL_SCALE, "percent above full scale")

  // A stalled result holds until transfer
  `MPI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(moisture_percent_o) && $stable(result_valid_o), "stalled result changed")

  // Empty and ready to take a reading on the first edge after reset
  `MPI_ASSERT_ALWAYS(a_reset_empty, clk_i, rst_ni && !$past(rst_ni), !out_valid_o && in_ready_o, "not empty right after reset")

endmodule

bind moisture_piecewise_interpolator mpi_checker u_mpi_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .moisture_percent_o (moisture_percent_o),
  .result_valid_o     (result_valid_o)
);
